[design/dfsr_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dfsr_pkg - shared types and constants of the display frame sync responder
// Event codes, register indexes, decoded parameter ids, response frame
// constants and the result burst descriptor passed to the output sequencer.
// ----------------------------------------------------------------------------
package dfsr_pkg;

  localparam int FRAME_LEN = 20;
  // the checksum byte is never kept, so the window holds one byte less
  localparam int WIN_DEPTH = FRAME_LEN - 1;
  localparam int RESP_LEN  = 14;

  localparam logic [15:0] IB_TIMEOUT_RST   = 16'd50;
  localparam logic [15:0] LINK_TIMEOUT_RST = 16'd1000;
  localparam logic [15:0] CONFIRM_RST      = 16'd500;

  localparam logic [7:0] RESP_START   = 8'h02;
  localparam logic [7:0] RESP_LENGTH  = 8'h0E;
  localparam logic [7:0] RESP_CMD     = 8'h01;
  localparam logic [7:0] RESP_END     = 8'hFF;
  localparam logic [7:0] NIBBLE_MASK  = 8'h0F;
  // xor of the constant response bytes
  localparam logic [7:0] RESP_XOR_SEED = RESP_START ^ RESP_LENGTH ^ RESP_CMD ^ RESP_END;

  typedef enum logic [2:0] {
    EV_NONE    = 3'd0,
    EV_STORED  = 3'd1,
    EV_SLID    = 3'd2,
    EV_IBRESET = 3'd3,
    EV_LOST    = 3'd4
  } event_e;

  typedef enum logic [1:0] {
    CFG_IB_TIMEOUT   = 2'd0,
    CFG_LINK_TIMEOUT = 2'd1,
    CFG_CONFIRM      = 2'd2
  } cfg_idx_e;

  typedef enum logic [3:0] {
    PID_ASSIST        = 4'd0,
    PID_THROTTLE      = 4'd1,
    PID_HEADLIGHT     = 4'd2,
    PID_PUSH_ASSIST   = 4'd3,
    PID_ZERO_START    = 4'd4,
    PID_SPEED_MAGNETS = 4'd5,
    PID_WHEEL_SIZE    = 4'd6,
    PID_START_DELAY   = 4'd7,
    PID_BOOST         = 4'd8,
    PID_SPEED_LIMIT   = 4'd9,
    PID_CURRENT_LIMIT = 4'd10,
    PID_VOLTAGE_MIN   = 4'd11,
    PID_PAS_MAGNETS   = 4'd12,
    PID_CRUISE        = 4'd13
  } param_id_e;

  // everything the output side needs to play back the beats of one item
  typedef struct packed {
    logic        is_resp;
    logic        two_ev;
    event_e      ev0;
    event_e      ev1;
    logic        link_up;
    logic [7:0]  err;
    logic        brake;
    logic [15:0] cur;
    logic [15:0] wt;
    logic [7:0]  f3;
    logic [7:0]  f4;
    logic [7:0]  f5;
    logic [7:0]  f6;
    logic [7:0]  f7;
    logic [7:0]  f8;
    logic [7:0]  f9;
    logic [7:0]  f10;
    logic [7:0]  f12;
    logic [7:0]  f13;
    logic [7:0]  f14;
    logic [7:0]  f15;
    logic [7:0]  f18;
  } burst_t;

endpackage

[design/dfsr_emitter.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dfsr_emitter - result beat sequencer
// Holds the burst being played out plus one pending burst, and turns each
// burst into its status beats or its fourteen response beats.
// ----------------------------------------------------------------------------
module dfsr_emitter (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push_i,
  input  dfsr_pkg::burst_t     burst_i,
  output logic                 ready_o,
  output logic                 m_valid_o,
  input  logic                 m_ready_i,
  output logic [31:0]          m_data_o,
  output logic                 m_user_o,
  output logic                 m_last_o
);

  dfsr_pkg::burst_t act_q, act_d, pend_q, pend_d;
  logic             act_v_q, act_v_d, pend_v_q, pend_v_d;
  logic [3:0]       beat_q, beat_d;

  logic             out_fire, last_beat, act_done, act_free;
  logic [7:0]       tx_byte, resp_xor;
  logic [15:0]      pval;
  logic [3:0]       pid;
  logic [2:0]       ev;

  assign ready_o   = !pend_v_q;
  assign out_fire  = act_v_q && m_ready_i;

  always_comb begin
    if (act_q.is_resp) begin
      last_beat = (beat_q == 4'(dfsr_pkg::RESP_LEN - 1));
    end else if (act_q.two_ev) begin
      last_beat = (beat_q == 4'd1);
    end else begin
      last_beat = (beat_q == 4'd0);
    end
  end

  assign act_done = out_fire && last_beat;
  assign act_free = !act_v_q || act_done;

  // slot and beat counter update
  always_comb begin
    act_d    = act_q;
    act_v_d  = act_v_q;
    pend_d   = pend_q;
    pend_v_d = pend_v_q;
    beat_d   = beat_q;
    if (act_done) begin
      beat_d = '0;
    end else if (out_fire) begin
      beat_d = beat_q + 4'd1;
    end
    if (act_free) begin
      if (pend_v_q) begin
        act_d    = pend_q;
        act_v_d  = 1'b1;
        pend_v_d = 1'b0;
      end else begin
        act_d   = burst_i;
        act_v_d = push_i;
      end
    end else if (push_i) begin
      pend_d   = burst_i;
      pend_v_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      act_v_q  <= 1'b0;
      pend_v_q <= 1'b0;
      beat_q   <= '0;
    end else begin
      act_v_q  <= act_v_d;
      pend_v_q <= pend_v_d;
      beat_q   <= beat_d;
    end
  end

  always_ff @(posedge clk_i) begin
    act_q  <= act_d;
    pend_q <= pend_d;
  end

  assign resp_xor = dfsr_pkg::RESP_XOR_SEED ^ act_q.err ^ {2'b00, act_q.brake, 5'b00000}
                  ^ act_q.cur[15:8] ^ act_q.cur[7:0] ^ act_q.wt[15:8] ^ act_q.wt[7:0];

  // response byte and decoded parameter of the current beat
  always_comb begin
    tx_byte = '0;
    pval    = '0;
    case (dfsr_pkg::param_id_e'(beat_q))
      dfsr_pkg::PID_ASSIST: begin
        tx_byte = dfsr_pkg::RESP_START;
        pval    = {8'h00, act_q.f4 & dfsr_pkg::NIBBLE_MASK};
      end
      dfsr_pkg::PID_THROTTLE: begin
        tx_byte = dfsr_pkg::RESP_LENGTH;
        pval    = {8'h00, act_q.f3};
      end
      dfsr_pkg::PID_HEADLIGHT: begin
        tx_byte = dfsr_pkg::RESP_CMD;
        pval    = {15'd0, act_q.f5[5]};
      end
      dfsr_pkg::PID_PUSH_ASSIST: begin
        tx_byte = act_q.err;
        pval    = {15'd0, act_q.f5[1]};
      end
      dfsr_pkg::PID_ZERO_START: begin
        tx_byte = {2'b00, act_q.brake, 5'b00000};
        pval    = {15'd0, act_q.f5[6]};
      end
      dfsr_pkg::PID_SPEED_MAGNETS: begin
        tx_byte = 8'h00;
        pval    = {8'h00, act_q.f6};
      end
      dfsr_pkg::PID_WHEEL_SIZE: begin
        tx_byte = act_q.cur[15:8];
        pval    = {act_q.f7, act_q.f8};
      end
      dfsr_pkg::PID_START_DELAY: begin
        tx_byte = act_q.cur[7:0];
        pval    = {8'h00, act_q.f9};
      end
      dfsr_pkg::PID_BOOST: begin
        tx_byte = act_q.wt[15:8];
        pval    = {8'h00, act_q.f10};
      end
      dfsr_pkg::PID_SPEED_LIMIT: begin
        tx_byte = act_q.wt[7:0];
        pval    = {8'h00, act_q.f12};
      end
      dfsr_pkg::PID_CURRENT_LIMIT: begin
        tx_byte = 8'h00;
        pval    = {8'h00, act_q.f13};
      end
      dfsr_pkg::PID_VOLTAGE_MIN: begin
        tx_byte = 8'h00;
        pval    = {act_q.f14, act_q.f15};
      end
      dfsr_pkg::PID_PAS_MAGNETS: begin
        tx_byte = dfsr_pkg::RESP_END;
        pval    = {8'h00, act_q.f18 & dfsr_pkg::NIBBLE_MASK};
      end
      dfsr_pkg::PID_CRUISE: begin
        tx_byte = resp_xor;
        pval    = {15'd0, act_q.f18[6]};
      end
      default: begin
        tx_byte = '0;
        pval    = '0;
      end
    endcase
  end

  always_comb begin
    if (act_q.is_resp) begin
      ev  = dfsr_pkg::EV_NONE;
      pid = beat_q;
    end else begin
      ev  = (beat_q == 4'd0) ? act_q.ev0 : act_q.ev1;
      pid = '0;
    end
  end

  assign m_valid_o = act_v_q;
  assign m_user_o  = act_q.is_resp;
  assign m_last_o  = last_beat;
  assign m_data_o  = {act_q.link_up,
                      act_q.is_resp ? pval : 16'd0,
                      pid,
                      act_q.is_resp ? tx_byte : 8'd0,
                      ev};

  a_pend_needs_act : assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_v_q |-> act_v_q)
    else $error("pending burst held with no active burst");

  a_resp_beat_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (act_v_q && act_q.is_resp) |-> (beat_q < 4'(dfsr_pkg::RESP_LEN)))
    else $error("response beat counter out of range");

  a_status_beat_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (act_v_q && !act_q.is_resp) |-> (beat_q <= {3'b000, act_q.two_ev}))
    else $error("status beat counter out of range");

endmodule

[design/display_frame_sync_responder.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// display_frame_sync_responder - display link frame sync and responder
// Collects display bytes in a sliding window, checks the frame checksum,
// answers valid frames and tracks link state from 1 ms ticks.
// ----------------------------------------------------------------------------
// An input beat is accepted in every cycle while the output side keeps up:
// its whole effect on the window and timers is worked out in the accepting
// cycle. Byte and tick beats give one or two status result beats, a byte
// ending a valid frame gives fourteen response beats, one per ready cycle.
// The output sequencer holds the burst being sent plus one pending burst,
// so input stalls only when a second item queues behind a burst still in
// flight; after a valid frame the beat behind the checksum byte is taken at
// once and the one after it waits while the response goes out.
module display_frame_sync_responder (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [15:0] cfg_wdata_i,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // rx_byte[7:0], err_code[15:8], brake_on[16], current_tenths[32:17],
  // wheel_period_ms[48:33], zero fill
  input  logic [55:0] s_axis_tdata,
  // req_type
  input  logic        s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // event_res[2:0], tx_byte[10:3], param_id[14:11], param_value[30:15],
  // link_up[31]
  output logic [31:0] m_axis_tdata,
  // result_kind
  output logic        m_axis_tuser,
  output logic        m_axis_tlast
);

  logic [15:0] ib_to_q, link_to_q, conf_q;
  logic [7:0]  win_q [dfsr_pkg::WIN_DEPTH];
  logic [7:0]  win_d [dfsr_pkg::WIN_DEPTH];
  logic [4:0]  fill_q, fill_d;
  logic [15:0] sb_q, sb_d, sv_q, sv_d, sf_q, sf_d;
  logic        fs_q, fs_d, conn_q, conn_d;

  logic        in_fire, req_type;
  logic [7:0]  rx_byte, cs;
  logic        ib_reset, link_lost;
  dfsr_pkg::burst_t burst;

  assign in_fire  = s_axis_tvalid && s_axis_tready;
  assign req_type = s_axis_tuser;
  assign rx_byte  = s_axis_tdata[7:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ib_to_q   <= dfsr_pkg::IB_TIMEOUT_RST;
      link_to_q <= dfsr_pkg::LINK_TIMEOUT_RST;
      conf_q    <= dfsr_pkg::CONFIRM_RST;
    end else if (cfg_we_i) begin
      case (dfsr_pkg::cfg_idx_e'(cfg_idx_i))
        dfsr_pkg::CFG_IB_TIMEOUT:   ib_to_q   <= cfg_wdata_i;
        dfsr_pkg::CFG_LINK_TIMEOUT: link_to_q <= cfg_wdata_i;
        dfsr_pkg::CFG_CONFIRM:      conf_q    <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  always_comb begin
    cs = '0;
    for (int i = 0; i < dfsr_pkg::WIN_DEPTH; i++) begin
      cs = cs ^ win_q[i];
    end
  end

  always_comb begin
    win_d     = win_q;
    fill_d    = fill_q;
    sb_d      = sb_q;
    sv_d      = sv_q;
    sf_d      = sf_q;
    fs_d      = fs_q;
    conn_d    = conn_q;
    ib_reset  = 1'b0;
    link_lost = 1'b0;
    burst     = '0;
    burst.err   = s_axis_tdata[15:8];
    burst.brake = s_axis_tdata[16];
    burst.cur   = s_axis_tdata[32:17];
    burst.wt    = s_axis_tdata[48:33];
    burst.f3    = win_q[3];
    burst.f4    = win_q[4];
    burst.f5    = win_q[5];
    burst.f6    = win_q[6];
    burst.f7    = win_q[7];
    burst.f8    = win_q[8];
    burst.f9    = win_q[9];
    burst.f10   = win_q[10];
    burst.f12   = win_q[12];
    burst.f13   = win_q[13];
    burst.f14   = win_q[14];
    burst.f15   = win_q[15];
    burst.f18   = win_q[18];
    burst.ev0   = dfsr_pkg::EV_NONE;
    burst.ev1   = dfsr_pkg::EV_LOST;
    if (in_fire) begin
      if (!req_type) begin
        sb_d = '0;
        if (fill_q == 5'(dfsr_pkg::WIN_DEPTH)) begin
          // this byte is the checksum of a full frame
          if (cs == rx_byte) begin
            burst.is_resp = 1'b1;
            sv_d   = '0;
            fill_d = '0;
            if (!fs_q) begin
              fs_d = 1'b1;
              sf_d = '0;
            end
            if (!conn_q && (sf_d >= conf_q)) begin
              conn_d = 1'b1;
            end
          end else begin
            for (int i = 0; i < dfsr_pkg::WIN_DEPTH - 1; i++) begin
              win_d[i] = win_q[i+1];
            end
            win_d[dfsr_pkg::WIN_DEPTH-1] = rx_byte;
            burst.ev0 = dfsr_pkg::EV_SLID;
          end
        end else begin
          for (int i = 0; i < dfsr_pkg::WIN_DEPTH; i++) begin
            if (5'(i) == fill_q) begin
              win_d[i] = rx_byte;
            end
          end
          fill_d    = fill_q + 5'd1;
          burst.ev0 = dfsr_pkg::EV_STORED;
        end
      end else begin
        sb_d = (sb_q == 16'hFFFF) ? sb_q : sb_q + 16'd1;
        sv_d = (sv_q == 16'hFFFF) ? sv_q : sv_q + 16'd1;
        sf_d = (sf_q == 16'hFFFF) ? sf_q : sf_q + 16'd1;
      end

      if ((fill_d != '0) && (sb_d > ib_to_q)) begin
        ib_reset = 1'b1;
        fill_d   = '0;
      end
      if (conn_d && (sv_d > link_to_q)) begin
        link_lost = 1'b1;
        conn_d    = 1'b0;
        fs_d      = 1'b0;
      end
      // stale first frame while the link is down
      if (!conn_d && fs_d && (sv_d > link_to_q)) begin
        fs_d = 1'b0;
      end

      if (!req_type) begin
        burst.two_ev = link_lost;
      end else if (ib_reset) begin
        burst.ev0    = dfsr_pkg::EV_IBRESET;
        burst.two_ev = link_lost;
      end else if (link_lost) begin
        burst.ev0 = dfsr_pkg::EV_LOST;
      end
    end
    burst.link_up = conn_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q <= '0;
      sb_q   <= '0;
      sv_q   <= '0;
      sf_q   <= '0;
      fs_q   <= 1'b0;
      conn_q <= 1'b0;
    end else begin
      fill_q <= fill_d;
      sb_q   <= sb_d;
      sv_q   <= sv_d;
      sf_q   <= sf_d;
      fs_q   <= fs_d;
      conn_q <= conn_d;
    end
  end

  always_ff @(posedge clk_i) begin
    win_q <= win_d;
  end

  dfsr_emitter u_emitter (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .push_i    (in_fire),
    .burst_i   (burst),
    .ready_o   (s_axis_tready),
    .m_valid_o (m_axis_tvalid),
    .m_ready_i (m_axis_tready),
    .m_data_o  (m_axis_tdata),
    .m_user_o  (m_axis_tuser),
    .m_last_o  (m_axis_tlast)
  );

  a_fill_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= 5'(dfsr_pkg::WIN_DEPTH))
    else $error("window fill count beyond window depth");

  a_link_has_first : assert property (@(posedge clk_i) disable iff (!rst_ni)
    conn_q |-> fs_q)
    else $error("link up without a first frame seen");

  a_byte_clears_timer : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && !req_type) |=> (sb_q == 16'd0))
    else $error("byte beat did not clear interbyte timer");

endmodule
